// ===== hw/rtl/hlfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hlfc_pkg;

	localparam int ANGLE_COUNT_DEF     = 360;
	localparam int COORD_FRAC_BITS_DEF = 14;
	localparam int QUEUE_DEPTH_DEF     = 8;

	localparam int RHO_W   = 14;
	localparam int ANG_W   = 9;
	localparam int DIM_W   = 13;
	localparam int TRIG_W  = 18;
	localparam int PROD_W  = 32;
	localparam int NUM_W   = 33;
	localparam int MAG_W   = 32;
	localparam int COORD_W = 16;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	localparam longint unsigned DEG_Q30 = 64'd18740330;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SIDE_RIGHT  = 2'd0,
		SIDE_LEFT   = 2'd1,
		SIDE_TOP    = 2'd2,
		SIDE_BOTTOM = 2'd3
	} side_t;

	typedef struct packed {
		logic [MAG_W-1:0] un;
		logic [MAG_W-1:0] ud;
		logic             neg;
		side_t            side;
	} slot_t;

	typedef struct packed {
		logic [1:0] count;
		logic       last;
		slot_t      s0;
		slot_t      s1;
	} job_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	typedef logic [16:0] sin_tab_t [0:90];

	// Long division by shift and subtract, used only while building the table.
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// First quadrant sine in Q16 from an eight term series in Q30.
	function automatic logic [16:0] sin_q16(input int unsigned k);
		longint unsigned x;
		longint unsigned t;
		longint unsigned s;
		longint unsigned d;
		int unsigned n;
		x = longint'(k) * DEG_Q30;
		t = x;
		s = x;
		for (n = 1; n <= 7; n++) begin
			t = (((t * x) >> 30) * x) >> 30;
			d = longint'((2 * n) * (2 * n + 1));
			t = udiv64(t, d);
			if (n[0])
				s = s - t;
			else
				s = s + t;
		end
		return 17'((s + 64'd8192) >> 14);
	endfunction

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t tab;
		for (int k = 0; k <= 90; k++)
			tab[k] = sin_q16(k);
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

	// Sine of a whole degree angle below 450, signed Q16.
	function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [ANG_W-1:0] a);
		logic [ANG_W-1:0] b;
		logic [6:0]       k;
		logic             neg;
		logic signed [TRIG_W-1:0] mag;
		b = (a >= 9'd360) ? a - 9'd360 : a;
		if (b <= 9'd90) begin
			k = 7'(b);
			neg = 1'b0;
		end else if (b <= 9'd180) begin
			k = 7'(9'd180 - b);
			neg = 1'b0;
		end else if (b <= 9'd270) begin
			k = 7'(b - 9'd180);
			neg = 1'b1;
		end else begin
			k = 7'(9'd360 - b);
			neg = 1'b1;
		end
		mag = $signed({1'b0, SIN_TAB[k]});
		return neg ? -mag : mag;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hough_line_frame_clip_top.sv =====
// Hough line to frame clipping.
// Each item on the line channel (line_valid, line_stall) is one line in normal
// form: rho and angle_deg, with last_line marking the end of a batch. Each line
// gives exactly one item on the result channel (result_valid, result_stall):
// up to two crossing points with the frame edges in signed Q2.14 coordinates,
// the number of points, and batch_end as a copy of last_line.
// Frame width and height are set through the APB port at byte addresses 0 and 4
// and must only be changed while no line is in flight.
// A line is taken in every cycle while line_stall is low. Each line passes
// through the four stage trig and multiply front end, the queue and the
// restoring dividers of the back end, which produce one quotient bit per stage,
// and then the output register.
// When the receiver stalls, the back end holds its pipeline and the result;
// the queue fills and line_stall rises once queued and in-flight lines fill it.
// Reset empties the pipeline and queue and restores a 640 by 480 frame.
`timescale 1ns / 1ps
`default_nettype none

module hough_line_frame_clip_top import hlfc_pkg::*; #(
	parameter int ANGLE_COUNT     = ANGLE_COUNT_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    line_valid,
	output logic                    line_stall,
	input  logic signed [RHO_W-1:0] rho,
	input  logic [ANG_W-1:0]        angle_deg,
	input  logic                    last_line,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [1:0]              point_count,
	output logic [COORD_W-1:0]      first_x,
	output logic [COORD_W-1:0]      first_y,
	output logic [COORD_W-1:0]      second_x,
	output logic [COORD_W-1:0]      second_y,
	output logic                    batch_end
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DIM_W-1:0] width_q, height_q;
	reg_idx_t         reg_idx;
	logic             push, pop, avail;
	job_t             job_in, job_out;
	logic [CNT_W-1:0] fifo_count;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			if (reg_idx == REG_FRAME_WIDTH)
				width_q <= pwdata[DIM_W-1:0];
			else
				height_q <= pwdata[DIM_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_FRAME_WIDTH) ? DATA_W'(width_q) : DATA_W'(height_q);

	hlfc_front #(
		.ANGLE_COUNT (ANGLE_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (line_valid),
		.stall        (line_stall),
		.rho          (rho),
		.angle_deg    (angle_deg),
		.last_line    (last_line),
		.frame_width  (width_q),
		.frame_height (height_q),
		.fifo_count   (fifo_count),
		.push         (push),
		.job          (job_in)
	);

	hlfc_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.dout   (job_out),
		.avail  (avail),
		.count  (fifo_count)
	);

	hlfc_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (avail),
		.head         (job_out),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.point_count  (point_count),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.batch_end    (batch_end)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/hlfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlfc_front import hlfc_pkg::*; #(
	parameter int ANGLE_COUNT = ANGLE_COUNT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	output logic                     stall,
	input  logic signed [RHO_W-1:0]  rho,
	input  logic [ANG_W-1:0]         angle_deg,
	input  logic                     last_line,
	input  logic [DIM_W-1:0]         frame_width,
	input  logic [DIM_W-1:0]         frame_height,
	input  logic [CNT_W-1:0]         fifo_count,
	output logic                     push,
	output job_t                     job
);

	localparam int SUM_W = CNT_W + 3;
	localparam logic [ANG_W-1:0] AC = ANG_W'(ANGLE_COUNT);

	logic v_s1, v_s2, v_s3, v_s4;
	logic accept;
	logic [2:0] inflight;

	logic [ANG_W-1:0] a1, a2;

	logic signed [RHO_W-1:0]  rho_s1;
	logic signed [TRIG_W-1:0] sin_s1, cos_s1;
	logic skip_rl_s1, skip_tb_s1, last_s1;

	logic signed [RHO_W:0]    rho2_s2;
	logic signed [PROD_W-1:0] wc_s2, hs_s2;
	logic skip_rl_s2, skip_tb_s2, last_s2;
	logic [DIM_W-1:0] w_eff, h_eff;

	logic signed [NUM_W-1:0] n_s3 [4];
	logic [MAG_W-1:0] ud_rl_s3, ud_tb_s3;
	logic dneg_rl_s3, dneg_tb_s3, dnz_rl_s3, dnz_tb_s3;
	logic skip_rl_s3, skip_tb_s3, last_s3;

	logic [MAG_W-1:0] un_s4 [4];
	logic             neg_s4 [4];
	logic [MAG_W-1:0] ud_rl_s4, ud_tb_s4;
	logic dnz_rl_s4, dnz_tb_s4, skip_rl_s4, skip_tb_s4, last_s4;

	logic [3:0] ok;
	logic [1:0] n_found;
	logic [1:0] idx0, idx1;

	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign stall = (SUM_W'(fifo_count) + SUM_W'(inflight)) >= SUM_W'(QUEUE_DEPTH);
	assign accept = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		a1 = (angle_deg >= AC) ? angle_deg - AC : angle_deg;
		a2 = (a1 >= AC) ? a1 - AC : a1;
	end

	always_ff @(posedge clk) begin
		rho_s1     <= rho;
		sin_s1     <= sin_lookup(a2);
		cos_s1     <= sin_lookup(a2 + 9'd90);
		skip_rl_s1 <= (a2 == 9'd0) || (a2 == 9'd180);
		skip_tb_s1 <= (a2 == 9'd90) || (a2 == 9'd270);
		last_s1    <= last_line;
	end

	assign w_eff = (frame_width == '0) ? DIM_W'(1) : frame_width;
	assign h_eff = (frame_height == '0) ? DIM_W'(1) : frame_height;

	always_ff @(posedge clk) begin
		rho2_s2    <= {rho_s1, 1'b0};
		wc_s2      <= PROD_W'($signed({1'b0, w_eff}) * cos_s1);
		hs_s2      <= PROD_W'($signed({1'b0, h_eff}) * sin_s1);
		skip_rl_s2 <= skip_rl_s1;
		skip_tb_s2 <= skip_tb_s1;
		last_s2    <= last_s1;
	end

	always_ff @(posedge clk) begin
		n_s3[0]    <= NUM_W'(rho2_s2) - NUM_W'(wc_s2);
		n_s3[1]    <= NUM_W'(rho2_s2) + NUM_W'(wc_s2);
		n_s3[2]    <= NUM_W'(rho2_s2) - NUM_W'(hs_s2);
		n_s3[3]    <= NUM_W'(rho2_s2) + NUM_W'(hs_s2);
		ud_rl_s3   <= hs_s2[PROD_W-1] ? MAG_W'(-hs_s2) : MAG_W'(hs_s2);
		ud_tb_s3   <= wc_s2[PROD_W-1] ? MAG_W'(-wc_s2) : MAG_W'(wc_s2);
		dneg_rl_s3 <= hs_s2[PROD_W-1];
		dneg_tb_s3 <= wc_s2[PROD_W-1];
		dnz_rl_s3  <= hs_s2 != '0;
		dnz_tb_s3  <= wc_s2 != '0;
		skip_rl_s3 <= skip_rl_s2;
		skip_tb_s3 <= skip_tb_s2;
		last_s3    <= last_s2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			un_s4[i]  <= n_s3[i][NUM_W-1] ? MAG_W'(-n_s3[i]) : MAG_W'(n_s3[i]);
			neg_s4[i] <= n_s3[i][NUM_W-1] ^ ((i < 2) ? dneg_rl_s3 : dneg_tb_s3);
		end
		ud_rl_s4   <= ud_rl_s3;
		ud_tb_s4   <= ud_tb_s3;
		dnz_rl_s4  <= dnz_rl_s3;
		dnz_tb_s4  <= dnz_tb_s3;
		skip_rl_s4 <= skip_rl_s3;
		skip_tb_s4 <= skip_tb_s3;
		last_s4    <= last_s3;
	end

	always_comb begin
		ok[0] = dnz_rl_s4 && !skip_rl_s4 && (un_s4[0] <= ud_rl_s4);
		ok[1] = dnz_rl_s4 && !skip_rl_s4 && (un_s4[1] <= ud_rl_s4);
		ok[2] = dnz_tb_s4 && !skip_tb_s4 && (un_s4[2] <= ud_tb_s4);
		ok[3] = dnz_tb_s4 && !skip_tb_s4 && (un_s4[3] <= ud_tb_s4);
		n_found = 2'd0;
		idx0 = 2'd0;
		idx1 = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (ok[i]) begin
				if (n_found == 2'd0) begin
					idx0 = 2'(i);
					n_found = 2'd1;
				end else if (n_found == 2'd1) begin
					idx1 = 2'(i);
					n_found = 2'd2;
				end
			end
		end
	end

	always_comb begin
		job.count   = n_found;
		job.last    = last_s4;
		job.s0.un   = un_s4[idx0];
		job.s0.ud   = idx0[1] ? ud_tb_s4 : ud_rl_s4;
		job.s0.neg  = neg_s4[idx0];
		job.s0.side = side_t'(idx0);
		job.s1.un   = un_s4[idx1];
		job.s1.ud   = idx1[1] ? ud_tb_s4 : ud_rl_s4;
		job.s1.neg  = neg_s4[idx1];
		job.s1.side = side_t'(idx1);
	end

	assign push = v_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/hlfc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlfc_fifo import hlfc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  job_t             din,
	input  logic             pop,
	output job_t             dout,
	output logic             avail,
	output logic [CNT_W-1:0] count
);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign avail  = cnt_q != '0;
	assign do_pop = pop && avail;
	assign count  = cnt_q;
	assign dout   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hlfc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlfc_div import hlfc_pkg::*; #(
	parameter int FRAC = COORD_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             en,
	input  logic [MAG_W-1:0] num,
	input  logic [MAG_W-1:0] den,
	output logic [FRAC:0]    quo
);

	localparam int NS = FRAC + 2;
	localparam int QW = FRAC + 2;

	logic [MAG_W-1:0] rem_s [NS];
	logic [MAG_W-1:0] den_s [NS];
	logic [QW-1:0]    quo_s [NS];
	logic [QW:0]      rnd;

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic [MAG_W:0]   sh;
		logic [MAG_W-1:0] d;
		logic [QW-1:0]    qp;
		logic             ge;
		if (i == 0) begin : g_first
			assign sh = {1'b0, num};
			assign d  = den;
			assign qp = '0;
		end else begin : g_next
			assign sh = {rem_s[i-1], 1'b0};
			assign d  = den_s[i-1];
			assign qp = quo_s[i-1];
		end
		assign ge = sh >= {1'b0, d};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? MAG_W'(sh - {1'b0, d}) : MAG_W'(sh);
				den_s[i] <= d;
				quo_s[i] <= {qp[QW-2:0], ge};
			end
		end
	end

	assign rnd = {1'b0, quo_s[NS-1]} + (QW+1)'(1);
	assign quo = rnd[QW-1:1];

endmodule

`default_nettype wire

// ===== hw/rtl/hlfc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlfc_back import hlfc_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  job_t               head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         point_count,
	output logic [COORD_W-1:0] first_x,
	output logic [COORD_W-1:0] first_y,
	output logic [COORD_W-1:0] second_x,
	output logic [COORD_W-1:0] second_y,
	output logic               batch_end
);

	localparam int NS    = COORD_FRAC_BITS + 2;
	localparam int VW    = COORD_FRAC_BITS + 1;
	localparam int CW    = COORD_FRAC_BITS + 2;
	localparam int SAT_W = (CW > 17) ? CW : 17;
	localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32767);
	localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-32768);
	localparam logic signed [CW-1:0] ONE = CW'(1) << COORD_FRAC_BITS;

	typedef struct packed {
		logic [1:0] count;
		logic       last;
		side_t      side0;
		logic       neg0;
		side_t      side1;
		logic       neg1;
	} meta_t;

	logic         en;
	logic         vld_s [NS];
	meta_t        meta_s [NS];
	logic [VW-1:0] v0, v1;
	point_t       p0, p1;
	logic         valid_q;
	logic [1:0]   count_q;
	point_t       first_q, second_q;
	logic         last_q;

	function automatic logic [COORD_W-1:0] sat(input logic signed [CW-1:0] val);
		logic signed [SAT_W-1:0] e;
		e = SAT_W'(val);
		if (e > SAT_MAX)
			e = SAT_MAX;
		else if (e < SAT_MIN)
			e = SAT_MIN;
		return COORD_W'(e);
	endfunction

	function automatic point_t make_point(input side_t side, input logic neg,
			input logic [VW-1:0] v, input logic found);
		logic signed [CW-1:0] free;
		point_t p;
		free = neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
		case (side)
			SIDE_RIGHT: begin
				p.x = sat(ONE);
				p.y = sat(free);
			end
			SIDE_LEFT: begin
				p.x = sat(-ONE);
				p.y = sat(free);
			end
			SIDE_TOP: begin
				p.x = sat(free);
				p.y = sat(ONE);
			end
			SIDE_BOTTOM: begin
				p.x = sat(free);
				p.y = sat(-ONE);
			end
			default: begin
				p.x = '0;
				p.y = '0;
			end
		endcase
		if (!found)
			p = '0;
		return p;
	endfunction

	assign en  = !valid_q || !result_stall;
	assign pop = en && avail;

	hlfc_div #(.FRAC(COORD_FRAC_BITS)) u_div0 (
		.clk (clk),
		.en  (en),
		.num (head.s0.un),
		.den (head.s0.ud),
		.quo (v0)
	);

	hlfc_div #(.FRAC(COORD_FRAC_BITS)) u_div1 (
		.clk (clk),
		.en  (en),
		.num (head.s1.un),
		.den (head.s1.ud),
		.quo (v1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++)
				vld_s[i] <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= avail;
			for (int i = 1; i < NS; i++)
				vld_s[i] <= vld_s[i-1];
			valid_q <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= '{count: head.count, last: head.last, side0: head.s0.side,
				neg0: head.s0.neg, side1: head.s1.side, neg1: head.s1.neg};
			for (int i = 1; i < NS; i++)
				meta_s[i] <= meta_s[i-1];
		end
	end

	assign p0 = make_point(meta_s[NS-1].side0, meta_s[NS-1].neg0, v0,
		meta_s[NS-1].count != 2'd0);
	assign p1 = make_point(meta_s[NS-1].side1, meta_s[NS-1].neg1, v1,
		meta_s[NS-1].count == 2'd2);

	always_ff @(posedge clk) begin
		if (en) begin
			count_q  <= meta_s[NS-1].count;
			first_q  <= p0;
			second_q <= p1;
			last_q   <= meta_s[NS-1].last;
		end
	end

	assign result_valid = valid_q;
	assign point_count  = count_q;
	assign first_x      = first_q.x;
	assign first_y      = first_q.y;
	assign second_x     = second_q.x;
	assign second_y     = second_q.y;
	assign batch_end    = last_q;

endmodule

`default_nettype wire
